// ===== hdl/pns_pkg.sv =====
`default_nettype none

package pns_pkg;

  localparam int NOTE_W  = 15;
  localparam int CONF_W  = 10;
  localparam int LEVEL_W = 12;
  localparam int SEMI_W  = 8;
  localparam int CENTS_W = 8;
  localparam int CNT_W   = 8;
  localparam int HIST_D  = 3;

  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_HOLD       = 2'd1;
  localparam logic [1:0] REG_HYSTERESIS = 2'd2;

  localparam logic [CONF_W-1:0] THRESHOLD_RST  = 10'd358;
  localparam logic [CNT_W-1:0]  HOLD_RST       = 8'd8;
  localparam logic [CNT_W-1:0]  HYSTERESIS_RST = 8'd166;

  typedef struct packed {
    logic                      pitch_found;
    logic [CONF_W-1:0]         confidence;
    logic [NOTE_W-1:0]         note_in;
    logic signed [LEVEL_W-1:0] level_in;
  } in_item_t;

  typedef struct packed {
    logic                      pitch_valid;
    logic [NOTE_W-1:0]         note_out;
    logic [SEMI_W-1:0]         nearest_semitone;
    logic signed [CENTS_W-1:0] cents_offset;
    logic [CONF_W-1:0]         confidence_out;
    logic signed [LEVEL_W-1:0] level_out;
  } out_item_t;

  typedef struct packed {
    logic [CONF_W-1:0] threshold;
    logic [CNT_W-1:0]  hold;
    logic [CNT_W-1:0]  hysteresis;
  } cfg_t;

  typedef struct packed {
    logic [HIST_D-1:0][NOTE_W-1:0] hist;
    logic [1:0]                    count;
    logic [CNT_W-1:0]              missed;
    logic                          shown_vld;
    logic [SEMI_W-1:0]             shown;
  } st_t;

endpackage

`default_nettype wire

// ===== hdl/pns_in_if.sv =====
`default_nettype none

interface pns_in_if;
  import pns_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pns_out_if.sv =====
`default_nettype none

interface pns_out_if;
  import pns_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pns_cfg.sv =====
`default_nettype none

module pns_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pns_pkg::APB_AW-1:0] paddr,
  input  wire logic [pns_pkg::APB_DW-1:0] pwdata,
  output logic      [pns_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output pns_pkg::cfg_t                   cfg
);
  import pns_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= THRESHOLD_RST;
      cfg_r.hold       <= HOLD_RST;
      cfg_r.hysteresis <= HYSTERESIS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD:  cfg_r.threshold  <= pwdata[CONF_W-1:0];
        REG_HOLD:       cfg_r.hold       <= pwdata[CNT_W-1:0];
        REG_HYSTERESIS: cfg_r.hysteresis <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD:  prdata = {{(APB_DW-CONF_W){1'b0}}, cfg_r.threshold};
      REG_HOLD:       prdata = {{(APB_DW-CNT_W){1'b0}}, cfg_r.hold};
      REG_HYSTERESIS: prdata = {{(APB_DW-CNT_W){1'b0}}, cfg_r.hysteresis};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pns_calc.sv =====
`default_nettype none

module pns_calc (
  input  pns_pkg::cfg_t     cfg,
  input  pns_pkg::in_item_t item,
  input  pns_pkg::st_t      st,
  output pns_pkg::st_t      st_nxt,
  output pns_pkg::out_item_t res
);
  import pns_pkg::*;

  function automatic logic [NOTE_W-1:0] median3(input logic [NOTE_W-1:0] a,
                                                input logic [NOTE_W-1:0] b,
                                                input logic [NOTE_W-1:0] c);
    logic [NOTE_W-1:0] lo;
    logic [NOTE_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    else if (c >= hi) return hi;
    else return c;
  endfunction

  logic                 take;
  logic [NOTE_W-1:0]    med;
  logic [NOTE_W:0]      rnd;
  logic [SEMI_W-1:0]    near;
  logic signed [NOTE_W+1:0] delta;
  logic [NOTE_W+1:0]    delta_abs;
  logic signed [NOTE_W+1:0] diff;
  logic signed [23:0]   prod;
  logic signed [23:0]   cents;

  always_comb begin
    st_nxt = st;
    take   = item.pitch_found && (item.confidence > cfg.threshold);

    // push accepted notes, count rejected frames
    if (take) begin
      st_nxt.hist[2] = st.hist[1];
      st_nxt.hist[1] = st.hist[0];
      st_nxt.hist[0] = item.note_in;
      if (st.count != 2'd3) st_nxt.count = st.count + 2'd1;
      st_nxt.missed = '0;
    end else begin
      if (st.missed != {CNT_W{1'b1}}) st_nxt.missed = st.missed + 8'd1;
      if (st_nxt.missed > cfg.hold) begin
        st_nxt.count     = '0;
        st_nxt.shown_vld = 1'b0;
        st_nxt.shown     = '0;
      end
    end

    med       = '0;
    near      = '0;
    cents     = '0;
    rnd       = '0;
    delta     = '0;
    delta_abs = '0;
    diff      = '0;
    prod      = '0;

    if (st_nxt.count != 2'd0) begin
      med = (st_nxt.count == 2'd3)
          ? median3(st_nxt.hist[0], st_nxt.hist[1], st_nxt.hist[2])
          : st_nxt.hist[0];
      rnd  = {1'b0, med} + 16'd128;
      near = rnd[NOTE_W:SEMI_W];
      // keep the shown note while the pitch stays within the band
      if (st_nxt.shown_vld) begin
        delta     = $signed({2'b00, med}) - $signed({1'b0, st_nxt.shown, 8'b0});
        delta_abs = delta[NOTE_W+1] ? 17'(-delta) : 17'(delta);
        if (delta_abs <= {9'b0, cfg.hysteresis}) near = st_nxt.shown;
      end
      st_nxt.shown_vld = 1'b1;
      st_nxt.shown     = near;

      diff  = $signed({2'b00, med}) - $signed({1'b0, near, 8'b0});
      // times 100 as 64 + 32 + 4
      prod  = (24'(diff) <<< 6) + (24'(diff) <<< 5) + (24'(diff) <<< 2);
      cents = prod >>> 8;
    end

    res.pitch_valid      = (st_nxt.count != 2'd0);
    res.note_out         = med;
    res.nearest_semitone = near;
    res.cents_offset     = cents[CENTS_W-1:0];
    res.confidence_out   = item.confidence;
    res.level_out        = item.level_in;
  end

endmodule

`default_nettype wire

// ===== hdl/pns_pipe.sv =====
`default_nettype none

module pns_pipe (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  pns_pkg::cfg_t cfg,
  pns_in_if.sink      in_chan,
  pns_out_if.source   out_chan
);
  import pns_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r;
  logic      out_vld_r;
  st_t       st_r;
  st_t       st_nxt;
  out_item_t res;
  logic      advance;
  logic      take_in;

  pns_calc u_calc (
    .cfg    (cfg),
    .item   (in_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // move the held request into the result register when that slot frees up
  assign advance        = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready  = !in_vld_r || advance;
  assign take_in        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (take_in) in_vld_r <= 1'b1;
      else if (advance) in_vld_r <= 1'b0;
      if (advance) out_vld_r <= 1'b1;
      else if (out_chan.ready) out_vld_r <= 1'b0;
      if (advance) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) in_r <= in_chan.data;
    if (advance) out_r <= res;
  end

endmodule

`default_nettype wire

// ===== hdl/pitch_note_stabilizer_top.sv =====
// A request accepted into the input register moves to the result register once that
// slot is free; the result is offered to the output from the result register.
// Throughput: one request per cycle while the output is not stalled; the input and result registers keep both
// sides moving, and one combinational pass updates the history and display state.
// Reset: synchronous, active low; clears history, counters and shown note and
// loads the register defaults (threshold 358, hold 8, hysteresis 166).
`default_nettype none

module pitch_note_stabilizer_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pns_in_if.sink                          in_chan,
  pns_out_if.source                       out_chan,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pns_pkg::APB_AW-1:0] paddr,
  input  wire logic [pns_pkg::APB_DW-1:0] pwdata,
  output logic      [pns_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import pns_pkg::*;

  cfg_t cfg;

  pns_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pns_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ===== hdl/pns_checker.sv =====
`default_nettype none

module pns_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input pns_pkg::out_item_t       out_data
);
  import pns_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pitch_valid |->
      out_data.note_out == '0 && out_data.nearest_semitone == '0 &&
      out_data.cents_offset == '0)
    else $error("pitch fields not zero without a pitch");

  a_cents_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pitch_valid |->
      out_data.cents_offset >= -8'sd100 && out_data.cents_offset <= 8'sd100 &&
      out_data.nearest_semitone <= 8'd128)
    else $error("cents or semitone out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pitch_note_stabilizer_top pns_checker u_pns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

`default_nettype wire
